// ===== hdl/vfd_pkg.sv =====
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types and constants for the vision frame deframer.
// ----------------------------------------------------------------------------
package vfd_pkg;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 16;
   localparam int VALUE_W = 24;
   localparam int PAIRS   = 3;
   // frame positions 1..6 carry the three value pairs
   localparam int PAYLOAD_BYTES = 2 * PAIRS;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // 100.0 in 16 fractional bits
   localparam logic [VALUE_W-1:0] FULL_SCALE = 24'd6553600;
   // 6553600 = 200 * 32767 + 200
   localparam logic [7:0]         MAG_STEP   = 8'd200;
   localparam logic [14:0]        MAG_DIV    = 15'h7fff;

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h73;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h65;

   typedef enum logic {
      CSR_START_MARKER = 1'b0,
      CSR_END_MARKER   = 1'b1
   } csr_reg_type;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic signed [VALUE_W-1:0] value_type;

endpackage

// ===== hdl/vfd_scale.sv =====
// ----------------------------------------------------------------------------
// vfd_scale
// Maps one 16-bit word (flag in bit 15, magnitude m below) to a signed 8.16 value:
// round(m * 100 / 32767), minus 100 when bit 15 is set.
// ----------------------------------------------------------------------------
module vfd_scale (
   input  vfd_pkg::word_type  word,
   output vfd_pkg::value_type value
);
   import vfd_pkg::*;

   logic [14:0] mag;
   logic [22:0] prod;
   logic [22:0] biased;
   logic [7:0]  quo_hi;
   logic [14:0] quo_lo;
   logic [15:0] rem;
   logic [8:0]  frac;
   logic [VALUE_W-1:0] pos;

   // m*6553600/32767 = 200m + 200m/32767; the second term is rounded.
   // Division by 2^15-1: y = a*2^15 + b gives y = a*(2^15-1) + (a+b),
   // and a+b stays below twice the divisor, so one compare fixes it up.
   always_comb begin
      mag    = word[14:0];
      prod   = 23'({8'd0, mag} * {15'd0, MAG_STEP});
      biased = prod + 23'(MAG_DIV >> 1);
      quo_hi = biased[22:15];
      quo_lo = biased[14:0];
      rem    = {8'd0, quo_hi} + {1'b0, quo_lo};
      frac   = {1'b0, quo_hi} + 9'(rem >= {1'b0, MAG_DIV});
      pos    = {1'b0, prod} + 24'(frac);
      value  = word[WORD_W-1] ? value_type'(pos - FULL_SCALE) : value_type'(pos);
   end

endmodule

// ===== hdl/vision_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// vision_frame_deframer
// Frames serial bytes between start and end markers and decodes yaw,
// pitch and range as signed 8.16 values.
// ----------------------------------------------------------------------------
// Takes one byte beat per clock unless req_tready is low. While idle a byte
// equal to the start marker opens a frame; later bytes in positions 1-6 are
// stored, and a byte equal to the end marker (even in a data position)
// closes the frame and yields one result beat via the decode register, then
// the output register. Bytes 1-2, 3-4, 5-6 are read big-endian; a short
// frame reuses bytes left from earlier frames (zero after reset). A frame
// that reaches BUFFER_BYTES bytes without an end marker is dropped silently.
// Both stages stall under rsp_tready low, so req_tready only drops when both
// hold a result. Markers are set via the csr_ port at addresses 0x0 and 0x4.
// ----------------------------------------------------------------------------
module vision_frame_deframer #(
   parameter int BUFFER_BYTES = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   // rx_byte[7:0]
   input  logic [7:0]                 req_tdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // yaw_value[23:0], pitch_value[47:24], range_value[71:48]
   output logic [71:0]                rsp_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [vfd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [vfd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [vfd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import vfd_pkg::*;

   localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

   // configuration
   byte_type    start_marker_ff, end_marker_ff;
   csr_reg_type csr_sel;
   logic        csr_write;

   // framing state
   logic             collecting_ff, collecting_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] fill_inc;
   byte_type         frame_ff [PAYLOAD_BYTES];
   byte_type         frame_in [PAYLOAD_BYTES];
   logic             req_beat;
   logic             frame_done;

   // decode stage and output stage
   logic      dec_valid_ff, dec_valid_in;
   word_type  dec_word_ff [PAIRS];
   value_type dec_value [PAIRS];
   logic      out_valid_ff, out_valid_in;
   logic [71:0] out_data_ff;
   logic      out_open, dec_open;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            CSR_START_MARKER: start_marker_ff <= csr_pwdata[BYTE_W-1:0];
            CSR_END_MARKER:   end_marker_ff   <= csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_START_MARKER: csr_prdata = {(CSR_DATA_W-BYTE_W)'(0), start_marker_ff};
         CSR_END_MARKER:   csr_prdata = {(CSR_DATA_W-BYTE_W)'(0), end_marker_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   assign out_open   = ~out_valid_ff | rsp_tready;
   assign dec_open   = ~dec_valid_ff | out_open;
   assign req_tready = dec_open;
   assign req_beat   = req_tvalid & req_tready;

   // ---------------- framing ----------------
   assign fill_inc = fill_ff + CNT_W'(1);

   always_comb begin
      collecting_in = collecting_ff;
      fill_in       = fill_ff;
      frame_done    = 1'b0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         frame_in[i] = frame_ff[i];
      end
      if (req_beat) begin
         if (!collecting_ff) begin
            if (req_tdata == start_marker_ff) begin
               collecting_in = 1'b1;
               fill_in       = CNT_W'(1);
            end
         end else begin
            // only positions 1..6 are ever decoded
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
               if (fill_ff == CNT_W'(i + 1)) begin
                  frame_in[i] = req_tdata;
               end
            end
            fill_in = fill_inc;
            if (req_tdata == end_marker_ff) begin
               frame_done    = 1'b1;
               collecting_in = 1'b0;
               fill_in       = '0;
            end else if (fill_inc >= CNT_W'(BUFFER_BYTES)) begin
               collecting_in = 1'b0;
               fill_in       = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         fill_ff       <= '0;
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            frame_ff[i] <= '0;
         end
      end else begin
         collecting_ff <= collecting_in;
         fill_ff       <= fill_in;
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            frame_ff[i] <= frame_in[i];
         end
      end
   end

   // ---------------- decode register ----------------
   always_comb begin
      dec_valid_in = dec_valid_ff;
      if (dec_open) begin
         dec_valid_in = frame_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= dec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         for (int p = 0; p < PAIRS; p++) begin
            dec_word_ff[p] <= {frame_in[2*p], frame_in[2*p+1]};
         end
      end
   end

   for (genvar p = 0; p < PAIRS; p++) begin : g_scale
      vfd_scale u_scale (
         .word  (dec_word_ff[p]),
         .value (dec_value[p])
      );
   end

   // ---------------- output register ----------------
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_open) begin
         out_valid_in = dec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_open && dec_valid_ff) begin
         out_data_ff <= {dec_value[2], dec_value[1], dec_value[0]};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== dv/vision_frame_deframer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vision_frame_deframer_test
// Self-checking bench for the vision frame deframer: a byte table and then
// random frames, overlong frames and noise under several marker settings.
// Every beat is checked field by field against a local decoder or typed row.
// ----------------------------------------------------------------------------
module vision_frame_deframer_test;
   import vfd_pkg::*;

   localparam int BUFFER_BYTES = 10;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 8;
   localparam int PHASES       = 7;
   localparam int PHASE_BYTES  = 220;

   localparam value_type TOP    = 24'sd6553600;
   localparam value_type BOTTOM = -24'sd6553600;

   typedef struct packed {
      value_type rng;
      value_type pitch;
      value_type yaw;
   } frame_type;

   typedef struct packed {
      byte_type  rx;
      logic      typed;
      frame_type res;
   } probe_row_type;

   // default markers: open 0x73, close 0x65
   localparam probe_row_type PROBES [24] = '{
      '{8'h65, 1'b0, '0},                         // close marker while idle
      '{8'h73, 1'b0, '0},
      '{8'h12, 1'b0, '0},
      '{8'h65, 1'b0, '0},                         // short, close marker as data
      '{8'h73, 1'b0, '0},
      '{8'h7f, 1'b0, '0}, '{8'hff, 1'b0, '0},
      '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'hff, 1'b0, '0}, '{8'hff, 1'b0, '0},
      '{8'h65, 1'b1, '{24'sd0, BOTTOM, TOP}},     // full scale both ways
      '{8'h73, 1'b0, '0},
      '{8'h65, 1'b0, '0},                         // short, stale bytes
      '{8'h73, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'hff, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'hff, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hff, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'hff, 1'b0, '0}, '{8'h00, 1'b0, '0}  // overlong, dropped
   };

   localparam byte_type OPEN_SET  [4] = '{8'h73, 8'h00, 8'hff, 8'h5a};
   localparam byte_type CLOSE_SET [4] = '{8'h65, 8'hff, 8'h00, 8'h5a};

   logic                  clock;
   logic                  reset;
   logic [7:0]            req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [71:0]           rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   vision_frame_deframer #(.BUFFER_BYTES(BUFFER_BYTES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // decoder state
   byte_type    open_mark;
   byte_type    close_mark;
   logic        in_frame;
   int unsigned fill_n;
   byte_type    frame_store [BUFFER_BYTES];

   frame_type pending_frames [$];
   int     errors = 0;
   int     bytes_sent;
   int     frames_checked = 0;
   int     frames_dropped;
   int     settings_run;
   bit     src_steady;
   logic   sink_steady;
   int     hold_token;
   int     hold_seen = 0;
   int     hold_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic value_type scale_pair(input byte_type hi, input byte_type lo);
      word_type          w;
      longint unsigned   mag;
      longint unsigned   pos;
      longint unsigned   full;
      longint unsigned   div;
      logic [VALUE_W-1:0] v;
      w    = {hi, lo};
      full = 64'(FULL_SCALE);
      div  = 64'(MAG_DIV);
      mag  = 64'(w[14:0]);
      // m * 100 / 32767 in 16 fractional bits, rounded to nearest
      pos  = (2 * mag * full + div) / (2 * div);
      v    = pos[VALUE_W-1:0];
      if (w[15]) begin
         v = v - FULL_SCALE;
      end
      return value_type'(v);
   endfunction

   task automatic deframe_step(input byte_type b, output logic fired, output frame_type res);
      fired = 1'b0;
      res   = '0;
      if (!in_frame) begin
         if (b == open_mark) begin
            frame_store[0] = b;
            fill_n   = 1;
            in_frame = 1'b1;
         end
      end else begin
         if (fill_n < BUFFER_BYTES) begin
            frame_store[fill_n] = b;
         end
         fill_n++;
         if (b == close_mark) begin
            res.yaw   = scale_pair(frame_store[1], frame_store[2]);
            res.pitch = scale_pair(frame_store[3], frame_store[4]);
            res.rng   = scale_pair(frame_store[5], frame_store[6]);
            fired    = 1'b1;
            fill_n   = 0;
            in_frame = 1'b0;
         end else if (fill_n >= BUFFER_BYTES) begin
            fill_n   = 0;
            in_frame = 1'b0;
            frames_dropped++;
         end
      end
   endtask

   task automatic send_byte(input byte_type b, input logic use_typed,
                            input frame_type typed_res);
      logic      fired;
      frame_type res;
      req_tdata  <= b;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      deframe_step(b, fired, res);
      if (fired) begin
         pending_frames.push_back(use_typed ? typed_res : res);
      end
      if (!src_steady && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         while ($urandom_range(99) < 27) @(posedge clock);
         @(posedge clock);
      end
   endtask

   function automatic byte_type pick_payload();
      byte_type b;
      if ($urandom_range(99) < 20) begin
         case ($urandom_range(3))
            0: b = 8'h00;
            1: b = 8'h7f;
            2: b = 8'h80;
            default: b = 8'hff;
         endcase
      end else begin
         b = byte_type'($urandom_range(255));
      end
      if (b == close_mark) begin
         b = b ^ 8'h01;
      end
      return b;
   endfunction

   task automatic run_traffic(input int budget, input bit pause_midway);
      int  start_count;
      int  len;
      int  k;
      bit  paused;
      start_count = bytes_sent;
      paused      = 1'b0;
      while (bytes_sent - start_count < budget) begin
         k = $urandom_range(99);
         if (k < 70) begin
            len = ($urandom_range(99) < 70) ? 6 : $urandom_range(8);
            send_byte(open_mark, 1'b0, '0);
            repeat (len) send_byte(pick_payload(), 1'b0, '0);
            send_byte(close_mark, 1'b0, '0);
         end else if (k < 85) begin
            send_byte(open_mark, 1'b0, '0);
            repeat ($urandom_range(9, 12)) send_byte(pick_payload(), 1'b0, '0);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_byte(byte_type'($urandom_range(255)), 1'b0, '0);
            end
         end
         if (pause_midway && !paused && bytes_sent - start_count > budget / 2) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_frames.size() != 0);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input csr_reg_type idx, input byte_type val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {{(CSR_DATA_W-BYTE_W){1'b0}}, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == CSR_START_MARKER) begin
         open_mark = val;
      end else begin
         close_mark = val;
      end
      @(posedge clock);
   endtask

   task automatic csr_check(input csr_reg_type idx);
      logic [CSR_DATA_W-1:0] want;
      want = {{(CSR_DATA_W-BYTE_W){1'b0}},
              (idx == CSR_START_MARKER) ? open_mark : close_mark};
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want) begin
         $display("%0t csr %s readback: expected %h, got %h",
                  $time, idx.name(), want, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string tag, input value_type want, input value_type got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %0d, got %0d", $time, tag, want, got);
         errors++;
      end
   endtask

   // result side: check accepted beats, then pick next tready
   always @(posedge clock) begin
      frame_type want;
      frame_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_frames.size() == 0) begin
            $display("%0t unexpected result beat: expected none, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_frames.pop_front();
            check_field("yaw", want.yaw, got.yaw);
            check_field("pitch", want.pitch, got.pitch);
            check_field("range", want.rng, got.rng);
            frames_checked++;
         end
      end
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= sink_steady || ($urandom_range(99) >= 27);
      end
   end

   initial begin
      byte_type o;
      byte_type c;
      clock          = 1'b0;
      reset          = 1'b1;
      req_tdata      = '0;
      req_tvalid     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      open_mark      = START_MARKER_RESET;
      close_mark     = END_MARKER_RESET;
      in_frame       = 1'b0;
      fill_n         = 0;
      foreach (frame_store[i]) frame_store[i] = '0;
      bytes_sent     = 0;
      frames_dropped = 0;
      settings_run   = 1;
      src_steady     = 1'b0;
      sink_steady    = 1'b0;
      hold_token     = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_check(CSR_START_MARKER);
      csr_check(CSR_END_MARKER);

      foreach (PROBES[i]) begin
         send_byte(PROBES[i].rx, PROBES[i].typed, PROBES[i].res);
      end
      req_tvalid <= 1'b0;
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 4) begin
            o = OPEN_SET[ph];
            c = CLOSE_SET[ph];
         end else begin
            o = byte_type'($urandom_range(255));
            c = byte_type'($urandom_range(255));
         end
         csr_write(CSR_START_MARKER, o);
         csr_write(CSR_END_MARKER, c);
         csr_check(CSR_START_MARKER);
         csr_check(CSR_END_MARKER);
         settings_run++;
         if (ph == 0) begin
            // long sink stall so the pipe fills and backs up req_tready
            hold_token <= hold_token + 1;
         end
         if (ph == PHASES - 1) begin
            src_steady   = 1'b1;
            sink_steady <= 1'b1;
         end
         run_traffic(PHASE_BYTES, ph == 0);
         drain();
      end

      $display("covered %0d bytes over %0d marker settings: %0d frames decoded, %0d dropped",
               bytes_sent, settings_run, frames_checked, frames_dropped);
      if (errors == 0) begin
         $display("vision_frame_deframer_test: clean");
      end else begin
         $display("vision_frame_deframer_test: errors");
      end
      $finish;
   end

   initial begin
      #600000;
      $display("timeout with %0d result beats outstanding", pending_frames.size());
      $display("vision_frame_deframer_test: errors");
      $finish;
   end

endmodule
